>>> hw/rtl/lzss_bitstream_decompressor_macros.svh
// Assertion macros shared by the LZSS bit-stream decompressor RTL.
`ifndef LZSS_BITSTREAM_DECOMPRESSOR_MACROS_SVH
`define LZSS_BITSTREAM_DECOMPRESSOR_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define LBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define LBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lzssbd_pkg.sv
// Types and constants shared by the LZSS bit-stream decompressor modules.
package lzssbd_pkg;

  // Token format: one flag bit, then a literal or a window position and a length.
  localparam int WINDOW_BITS = 12;
  localparam int LENGTH_BITS = 4;
  localparam int WIN_SIZE    = 1 << WINDOW_BITS;
  localparam int LIT_BITS    = 8;
  localparam int TOKEN_BITS  = 1 + WINDOW_BITS + LENGTH_BITS;
  localparam int TCNT_BITS   = $clog2(TOKEN_BITS + 1);
  localparam int FILL_BITS   = WINDOW_BITS + 1;
  localparam int REM_BITS    = LENGTH_BITS + 1;
  localparam int COUNT_BITS  = 24;
  localparam int MIN_COPY    = 2;
  localparam int LEFT_BITS   = $clog2(LIT_BITS + 1);

  localparam logic [TCNT_BITS-1:0]  LIT_TOKEN_LEN  = TCNT_BITS'(1 + LIT_BITS);
  localparam logic [TCNT_BITS-1:0]  END_TOKEN_LEN  = TCNT_BITS'(1 + WINDOW_BITS);
  localparam logic [TCNT_BITS-1:0]  COPY_TOKEN_LEN = TCNT_BITS'(TOKEN_BITS);
  localparam logic [FILL_BITS-1:0]  FILL_MAX       = FILL_BITS'(WIN_SIZE);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX      = '1;
  localparam logic [LEFT_BITS-1:0]  BYTE_BITS      = LEFT_BITS'(LIT_BITS);

  // Input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_stream;
  } in_req_t;

  // Result request.
  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  byte_valid;
    logic                  stream_end;
    logic                  run_last;
    logic [COUNT_BITS-1:0] total_out;
  } out_req_t;

  // Token completed by the bit being shifted in.
  typedef enum logic [1:0] {
    EV_NONE,
    EV_LIT,
    EV_END,
    EV_COPY
  } tok_ev_t;

  // Kind of result the datapath produces.
  typedef enum logic [1:0] {
    EK_LIT,
    EK_COPY,
    EK_END
  } emit_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       shift;
    logic       rd;
    logic       emit;
    emit_kind_t kind;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    tok_ev_t ev;
    logic    last_bit;
    logic    byte_empty;
    logic    ended;
    logic    out_free;
    logic    copy_last;
  } dp_stat_t;

endpackage

>>> hw/rtl/lzssbd_ctrl.sv
// Controller state machine of the LZSS bit-stream decompressor.
`include "lzss_bitstream_decompressor_macros.svh"

module lzssbd_ctrl import lzssbd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_BITS = 6'b000010,
    S_LIT  = 6'b000100,
    S_END  = 6'b001000,
    S_RD   = 6'b010000,
    S_WR   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // A new byte is taken only when the previous one is fully worked off.
  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = EK_LIT;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_BITS;
        end
      end
      S_BITS: begin
        if (st.ended) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.shift = 1'b1;
          case (st.ev)
            EV_LIT:  state_nxt = S_LIT;
            EV_END:  state_nxt = S_END;
            EV_COPY: state_nxt = S_RD;
            default: state_nxt = st.last_bit ? S_IDLE : S_BITS;
          endcase
        end
      end
      S_LIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_LIT;
          state_nxt = st.byte_empty ? S_IDLE : S_BITS;
        end
      end
      S_END: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_END;
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = EK_COPY;
          if (st.copy_last) begin
            state_nxt = st.byte_empty ? S_IDLE : S_BITS;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `LBD_ASSERT(a_no_shift_after_end, !cmd.shift || !st.ended, "bit shifted after stream end")
  `LBD_ASSERT(a_emit_in_emit_state, !cmd.emit || state_r == S_LIT || state_r == S_END || state_r == S_WR, "result issued outside an emit state")
  `LBD_ASSERT_NEXT(a_read_then_write, state_r == S_RD, state_r == S_WR, "window read not followed by copy write")

endmodule

>>> hw/rtl/lzssbd_dp.sv
// Datapath of the LZSS bit-stream decompressor: bit reader, window and result register.
`include "lzss_bitstream_decompressor_macros.svh"

module lzssbd_dp import lzssbd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_data,
  input  dp_cmd_t  cmd,
  output dp_stat_t st,
  input  logic     out_stall,
  output logic     out_valid,
  output out_req_t out_data
);

  // Bit reader state.
  logic [7:0]            byte_r;
  logic [LEFT_BITS-1:0]  left_r;
  logic [TOKEN_BITS-1:0] tok_r;
  logic [TCNT_BITS-1:0]  tcnt_r;
  logic                  flag_r;
  logic                  ended_r;

  // Window and stream state.
  logic [7:0]             mem [WIN_SIZE];
  logic [WINDOW_BITS-1:0] wpos_r;
  logic [FILL_BITS-1:0]   fill_r;
  logic [COUNT_BITS-1:0]  prod_r;

  // Decoded token and copy progress.
  logic [7:0]             lit_r;
  logic [WINDOW_BITS-1:0] src_r;
  logic [REM_BITS-1:0]    rem_r;
  logic [7:0]             rd_data_r;
  logic                   rd_ok_r;

  // Result register.
  logic     out_valid_r;
  out_req_t out_r;

  logic                   bit_in;
  logic [TOKEN_BITS-1:0]  tok_sh;
  logic [TCNT_BITS-1:0]   tcnt_inc;
  logic                   flag_cur;
  tok_ev_t                ev;
  logic [7:0]             emit_byte;
  logic                   emit_data;
  logic [COUNT_BITS-1:0]  prod_inc;
  logic [WINDOW_BITS-1:0] src_rel;
  logic                   out_free;

  // Shift in the next bit and see whether it completes a token.
  always_comb begin
    bit_in   = byte_r[7];
    tok_sh   = {tok_r[TOKEN_BITS-2:0], bit_in};
    tcnt_inc = tcnt_r + 1'b1;
    flag_cur = (tcnt_r == '0) ? bit_in : flag_r;
    if (flag_cur && tcnt_inc == LIT_TOKEN_LEN) begin
      ev = EV_LIT;
    end else if (!flag_cur && tcnt_inc == END_TOKEN_LEN && tok_sh[WINDOW_BITS-1:0] == '0) begin
      ev = EV_END;
    end else if (!flag_cur && tcnt_inc == COPY_TOKEN_LEN) begin
      ev = EV_COPY;
    end else begin
      ev = EV_NONE;
    end
  end

  // Byte for the result; window entries not yet written this stream read as zero.
  always_comb begin
    case (cmd.kind)
      EK_LIT:  emit_byte = lit_r;
      EK_COPY: emit_byte = rd_ok_r ? rd_data_r : 8'd0;
      default: emit_byte = 8'd0;
    endcase
    emit_data = cmd.emit && (cmd.kind != EK_END);
    prod_inc  = (prod_r == COUNT_MAX) ? prod_r : prod_r + 1'b1;
    src_rel   = src_r - WINDOW_BITS'(1);
    out_free  = !out_valid_r || !out_stall;
  end

  // Window memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (emit_data) begin
      mem[wpos_r] <= emit_byte;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[src_r];
      rd_ok_r   <= ({1'b0, src_rel} < fill_r);
    end
  end

  // Bit reader and stream control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= '0;
      tcnt_r  <= '0;
      ended_r <= 1'b0;
      wpos_r  <= WINDOW_BITS'(1);
      fill_r  <= '0;
      prod_r  <= '0;
      left_r  <= '0;
    end else begin
      if (cmd.load) begin
        left_r <= BYTE_BITS;
        if (in_data.start_stream) begin
          tok_r   <= '0;
          tcnt_r  <= '0;
          ended_r <= 1'b0;
          wpos_r  <= WINDOW_BITS'(1);
          fill_r  <= '0;
          prod_r  <= '0;
        end
      end
      if (cmd.shift) begin
        left_r <= left_r - 1'b1;
        if (ev == EV_NONE) begin
          tok_r  <= tok_sh;
          tcnt_r <= tcnt_inc;
        end else begin
          tok_r  <= '0;
          tcnt_r <= '0;
        end
        if (ev == EV_END) begin
          ended_r <= 1'b1;
        end
      end
      if (emit_data) begin
        wpos_r <= wpos_r + 1'b1;
        prod_r <= prod_inc;
        if (fill_r != FILL_MAX) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  // Payload registers of the reader and the copy.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_data.in_byte;
    end
    if (cmd.shift) begin
      byte_r <= {byte_r[6:0], 1'b0};
      flag_r <= flag_cur;
      lit_r  <= tok_sh[7:0];
      src_r  <= tok_sh[TOKEN_BITS-2:LENGTH_BITS];
      rem_r  <= {1'b0, tok_sh[LENGTH_BITS-1:0]} + REM_BITS'(MIN_COPY - 1);
    end
    if (emit_data && cmd.kind == EK_COPY) begin
      src_r <= src_r + 1'b1;
      rem_r <= rem_r - 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.out_byte   <= emit_byte;
      out_r.byte_valid <= emit_data;
      out_r.stream_end <= !emit_data;
      out_r.run_last   <= (cmd.kind != EK_COPY) || (rem_r == '0);
      out_r.total_out  <= emit_data ? prod_inc : prod_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status to the controller.
  always_comb begin
    st            = '0;
    st.ev         = ev;
    st.last_bit   = (left_r == LEFT_BITS'(1));
    st.byte_empty = (left_r == '0);
    st.ended      = ended_r;
    st.out_free   = out_free;
    st.copy_last  = (rem_r == '0);
  end

  `LBD_ASSERT(a_emit_needs_room, !cmd.emit || out_free, "result issued while result register is held")
  `LBD_ASSERT(a_fill_range, fill_r <= FILL_MAX, "window fill count out of range")
  `LBD_ASSERT_NEXT(a_copy_step, cmd.emit && cmd.kind == EK_COPY && rem_r != '0, rem_r == $past(rem_r) - 1'b1, "copy length did not step down")

endmodule

>>> hw/rtl/lzss_bitstream_decompressor.sv
// Top level of the LZSS bit-stream decompressor.
// Decodes a bit-packed LZSS stream (MSB first; 1 + 8-bit literal, or 0 + 12-bit absolute
// window position + 4-bit length copying length+2 bytes; position zero ends the stream)
// against a 4096-byte history window that starts at position 1. Each byte is taken,
// then its eight bits are shifted in one at a time; a literal or the end marker adds a
// result step, and a copy adds, for each copied byte, a registered window read, then the
// write and the result. Bytes after the end marker are taken and dropped. The single
// window RAM port pair sets the copy rate. The start flag needs no clearing pass: a fill
// count marks which window entries this stream has written, and the rest read as zero.
// A finished result waits in an output register while decoding goes on, and the block
// stalls only when a second result is ready before the first is taken.
module lzss_bitstream_decompressor import lzssbd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  // Sequencer.
  lzssbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Reader, window and result register.
  lzssbd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
